[sv/svm_pkg.sv]
// Shared types and constants for the sample voice mixer.
// Used by the front, queue, engine and top modules; no dependencies.
`default_nettype none

package svm_pkg;

    localparam int DEF_NUM_VOICES  = 6;
    localparam int DEF_MAX_FRAMES  = 65536;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int CMDQ_DEPTH      = 4;

    localparam logic [19:0] MIN_STEP   = 20'd3277;
    localparam logic [15:0] MIN_GAIN   = 16'd4;
    localparam logic [15:0] UNITY_GAIN = 16'd32768;
    localparam logic [19:0] UNITY_STEP = 20'd65536;
    localparam logic [14:0] CLIP_RESET = 15'd31130;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_LOAD  = 3'd1,
        OP_GAIN  = 3'd2,
        OP_SEEK  = 3'd3,
        OP_TICK  = 3'd4
    } op_t;

    // classified command, fields already clamped and quantized
    typedef struct packed {
        op_t         op;
        logic [2:0]  voice;
        logic [15:0] index;
        logic [31:0] frame;
        logic [16:0] length;
        logic        enable;
        logic [15:0] gain;
        logic [19:0] pitch;
    } item_t;

endpackage

`default_nettype wire

[sv/svm_cmdq.sv]
// Small command queue between the front decoder and the mixing engine.
// Depends on svm_pkg (item_t, CMDQ_DEPTH).
`default_nettype none

module svm_cmdq
    import svm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output item_t      head,
    output logic       empty
);

    localparam int PW = $clog2(CMDQ_DEPTH);

    item_t           slot_reg [CMDQ_DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full    = (cnt_reg == (PW+1)'(CMDQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[sv/svm_front.sv]
// Front end: takes input items, drops ones with no effect, clamps fields.
// Depends on svm_pkg (op_t, item_t, gain constants).
`default_nettype none

module svm_front
    import svm_pkg::*;
#(
    parameter int NUM_VOICES  = DEF_NUM_VOICES,
    parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  cmd,
    input  wire logic [2:0]  voice,
    input  wire logic [15:0] frame_index,
    input  wire logic [15:0] sample_left,
    input  wire logic [15:0] sample_right,
    input  wire logic [16:0] frame_count,
    input  wire logic        enable,
    input  wire logic [15:0] gain,
    input  wire logic [19:0] pitch,
    input  wire logic        q_full,
    output logic             q_push,
    output item_t            q_item
);

    localparam int          DROP  = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
    localparam logic [15:0] QMASK = 16'(16'hFFFF << DROP);

    logic keep;
    logic voice_ok;

    assign full     = q_full;
    assign voice_ok = (32'(voice) < 32'(NUM_VOICES));

    always_comb
    begin
        q_item.op     = OP_TICK;
        q_item.voice  = voice;
        q_item.index  = frame_index;
        q_item.frame  = {sample_left & QMASK, sample_right & QMASK};
        q_item.length = (32'(frame_count) > 32'(MAX_FRAMES)) ? 17'(MAX_FRAMES)
                                                             : frame_count;
        q_item.enable = enable;
        q_item.gain   = (gain > UNITY_GAIN) ? UNITY_GAIN : gain;
        q_item.pitch  = pitch;
        keep          = 1'b0;
        unique case (cmd)
            3'(OP_WRITE):
            begin
                q_item.op = OP_WRITE;
                keep      = voice_ok && (32'(frame_index) < 32'(MAX_FRAMES));
            end
            3'(OP_LOAD):
            begin
                q_item.op = OP_LOAD;
                keep      = voice_ok;
            end
            3'(OP_GAIN):
            begin
                q_item.op = OP_GAIN;
                keep      = voice_ok;
            end
            3'(OP_SEEK):
            begin
                q_item.op = OP_SEEK;
                keep      = voice_ok;
            end
            3'(OP_TICK):
            begin
                q_item.op = OP_TICK;
                keep      = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = push && !q_full && keep;

endmodule

`default_nettype wire

[sv/svm_rem.sv]
// Restoring remainder unit, one dividend bit per cycle.
// Standalone; used by the engine for seek wrap and position wrap.
`default_nettype none

module svm_rem
#(
    parameter int DW = 17,
    parameter int RW = 17
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [RW-1:0] divisor,
    output logic               busy,
    output logic               done,
    output logic [RW-1:0]      rem
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] dvd_reg;
    logic [RW-1:0] dsr_reg;
    logic [RW-1:0] rem_reg;
    logic          done_reg;
    logic [RW:0]   trial;
    logic [RW:0]   diff;

    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign busy  = (cnt_reg != '0);
    assign done  = done_reg;
    assign rem   = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy && (cnt_reg == CW'(1));
            if (start)
            begin
                cnt_reg <= CW'(DW);
            end
            else if (busy)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= diff[RW] ? trial[RW-1:0] : diff[RW-1:0];
        end
    end

endmodule

`default_nettype wire

[sv/svm_engine.sv]
// Back end: executes queued commands, holds voice state and sample memory,
// mixes one frame per tick one voice at a time. Depends on svm_pkg, svm_rem.
`default_nettype none

module svm_engine
    import svm_pkg::*;
#(
    parameter int NUM_VOICES = DEF_NUM_VOICES,
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    input  wire item_t       q_item,
    output logic             q_pop,
    input  wire logic [14:0] clip_level,
    output logic             out_valid,
    input  wire logic        out_pop,
    output logic [15:0]      out_left,
    output logic [15:0]      out_right
);

    localparam int VW        = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int FRAME_W   = $clog2(MAX_FRAMES);
    localparam int LEN_W     = $clog2(MAX_FRAMES + 1);
    localparam int DW        = ($clog2(MAX_FRAMES + 16) > 16) ? $clog2(MAX_FRAMES + 16) : 16;
    localparam int PW        = FRAME_W + 16;
    localparam int MEM_DEPTH = NUM_VOICES * MAX_FRAMES;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int ACC_W     = 18 + $clog2(NUM_VOICES);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_CHECK = 10'b00_0000_0010,
        S_SEEK  = 10'b00_0000_0100,
        S_RD0   = 10'b00_0000_1000,
        S_RD1   = 10'b00_0001_0000,
        S_LERP  = 10'b00_0010_0000,
        S_SCALE = 10'b00_0100_0000,
        S_ACC   = 10'b00_1000_0000,
        S_ADV   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // per-voice state
    logic [PW-1:0]    pos_reg   [NUM_VOICES];
    logic [LEN_W-1:0] len_reg   [NUM_VOICES];
    logic             en_reg    [NUM_VOICES];
    logic [15:0]      gain_reg  [NUM_VOICES];
    logic [19:0]      step_reg  [NUM_VOICES];
    logic [15:0]      seek_reg  [NUM_VOICES];
    logic             seekv_reg [NUM_VOICES];

    logic [31:0]      mem [MEM_DEPTH];
    logic [31:0]      rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             mem_we;

    logic [VW-1:0]    k_reg;
    logic [VW-1:0]    iv;
    logic             last_voice;
    logic [ACC_W-1:0] acc_reg;
    logic [31:0]      w0_reg;
    logic signed [33:0] pl_reg, pr_reg;
    logic signed [33:0] gl_reg, gr_reg;
    logic             out_valid_reg;
    logic [15:0]      out_l_reg, out_r_reg;

    // current voice view
    logic [PW-1:0]    cur_pos;
    logic [LEN_W-1:0] cur_len;
    logic [15:0]      cur_gain;
    logic [19:0]      step_eff;
    logic             active;
    logic [LEN_W-1:0] i0, i1, i0_inc;
    logic [DW+15:0]   sum;
    logic [DW-1:0]    sum_int;
    logic             wrap_fast;

    // remainder unit
    logic             rem_start;
    logic [DW-1:0]    rem_dvd;
    logic             rem_busy, rem_done;
    logic [LEN_W-1:0] rem_out;

    // datapath helpers
    logic signed [16:0] al, ar, bl, br, dl, dr, frac_s, vl, vr, gain_s;
    logic signed [33:0] pl_adj, pr_adj, tl, tr, gl_adj, gr_adj, cl, cr;
    logic signed [ACC_W-1:0] acc_s, clip_s;
    logic [15:0]      clip_l, clip_r;

    assign iv         = VW'(q_item.voice);
    assign last_voice = (k_reg == VW'(NUM_VOICES - 1));
    assign cur_pos    = pos_reg[k_reg];
    assign cur_len    = len_reg[k_reg];
    assign cur_gain   = gain_reg[k_reg];
    assign step_eff   = (step_reg[k_reg] < MIN_STEP) ? MIN_STEP : step_reg[k_reg];
    assign active     = en_reg[k_reg] && (cur_len != '0) && (cur_gain >= MIN_GAIN);

    assign i0        = LEN_W'(cur_pos[PW-1:16]);
    assign i0_inc    = i0 + 1'b1;
    assign i1        = (i0_inc < cur_len) ? i0_inc : '0;
    assign sum       = (DW+16)'(cur_pos) + (DW+16)'(step_eff);
    assign sum_int   = sum[DW+15:16];
    assign wrap_fast = (sum_int < DW'(cur_len));

    assign rem_dvd   = (state_reg == S_CHECK) ? DW'(seek_reg[k_reg]) : sum_int;
    assign rem_start = ((state_reg == S_CHECK) && active && seekv_reg[k_reg])
                    || ((state_reg == S_ACC) && !wrap_fast);

    svm_rem #(
        .DW (DW),
        .RW (LEN_W)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (rem_dvd),
        .divisor  (cur_len),
        .busy     (rem_busy),
        .done     (rem_done),
        .rem      (rem_out)
    );

    // sample memory
    assign mem_we  = (state_reg == S_IDLE) && !q_empty && (q_item.op == OP_WRITE);
    assign wr_addr = AW'(iv) * AW'(MAX_FRAMES) + AW'(q_item.index);
    assign rd_addr = AW'(k_reg) * AW'(MAX_FRAMES)
                   + AW'((state_reg == S_RD0) ? i0 : i1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= q_item.frame;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // interpolation and gain datapath
    always_comb
    begin
        al     = $signed({w0_reg[31], w0_reg[31:16]});
        ar     = $signed({w0_reg[15], w0_reg[15:0]});
        bl     = $signed({rd_data_reg[31], rd_data_reg[31:16]});
        br     = $signed({rd_data_reg[15], rd_data_reg[15:0]});
        dl     = bl - al;
        dr     = br - ar;
        frac_s = $signed({1'b0, cur_pos[15:0]});
        // truncate toward zero on the /65536
        pl_adj = pl_reg + (pl_reg[33] ? 34'sd65535 : 34'sd0);
        pr_adj = pr_reg + (pr_reg[33] ? 34'sd65535 : 34'sd0);
        tl     = pl_adj >>> 16;
        tr     = pr_adj >>> 16;
        vl     = al + $signed(tl[16:0]);
        vr     = ar + $signed(tr[16:0]);
        gain_s = $signed({1'b0, cur_gain});
        gl_adj = gl_reg + (gl_reg[33] ? 34'sd32767 : 34'sd0);
        gr_adj = gr_reg + (gr_reg[33] ? 34'sd32767 : 34'sd0);
        cl     = gl_adj >>> 15;
        cr     = gr_adj >>> 15;
        acc_s  = $signed(acc_reg);
        clip_s = $signed({{(ACC_W-15){1'b0}}, clip_level});
        clip_l = (acc_s > clip_s) ? 16'(clip_s)
               : (acc_s < -clip_s) ? 16'(-clip_s) : 16'(acc_s);
        clip_r = 16'(0);
    end

    // right channel accumulates in the same pass as the left; keep own acc
    logic [ACC_W-1:0] accr_reg;
    logic signed [ACC_W-1:0] accr_s;
    assign accr_s = $signed(accr_reg);

    logic [15:0] clip_rr;
    assign clip_rr = (accr_s > clip_s) ? 16'(clip_s)
                   : (accr_s < -clip_s) ? 16'(-clip_s) : 16'(accr_s);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD1)
        begin
            w0_reg <= rd_data_reg;
        end
        if (state_reg == S_LERP)
        begin
            pl_reg <= dl * frac_s;
            pr_reg <= dr * frac_s;
        end
        if (state_reg == S_SCALE)
        begin
            gl_reg <= vl * gain_s;
            gr_reg <= vr * gain_s;
        end
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_item.op == OP_TICK)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (!active)
                begin
                    state_next = last_voice ? S_OUT : S_CHECK;
                end
                else if (seekv_reg[k_reg])
                begin
                    state_next = S_SEEK;
                end
                else
                begin
                    state_next = S_RD0;
                end
            end
            S_SEEK:
            begin
                if (rem_done)
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0:   state_next = S_RD1;
            S_RD1:   state_next = S_LERP;
            S_LERP:  state_next = S_SCALE;
            S_SCALE: state_next = S_ACC;
            S_ACC:
            begin
                if (!wrap_fast)
                begin
                    state_next = S_ADV;
                end
                else
                begin
                    state_next = last_voice ? S_OUT : S_CHECK;
                end
            end
            S_ADV:
            begin
                if (rem_done)
                begin
                    state_next = last_voice ? S_OUT : S_CHECK;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_pop)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            acc_reg       <= '0;
            accr_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                pos_reg[v]   <= '0;
                len_reg[v]   <= '0;
                en_reg[v]    <= 1'b0;
                gain_reg[v]  <= '0;
                step_reg[v]  <= UNITY_STEP;
                seek_reg[v]  <= '0;
                seekv_reg[v] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // a new frame takes the slot as the old one leaves
            if ((state_reg == S_OUT) && (!out_valid_reg || out_pop))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    k_reg    <= '0;
                    acc_reg  <= '0;
                    accr_reg <= '0;
                    if (!q_empty)
                    begin
                        case (q_item.op)
                            OP_LOAD:
                            begin
                                len_reg[iv]   <= LEN_W'(q_item.length);
                                en_reg[iv]    <= q_item.enable;
                                pos_reg[iv]   <= '0;
                                seekv_reg[iv] <= 1'b0;
                                gain_reg[iv]  <= '0;
                                step_reg[iv]  <= UNITY_STEP;
                            end
                            OP_GAIN:
                            begin
                                gain_reg[iv] <= q_item.gain;
                                step_reg[iv] <= q_item.pitch;
                            end
                            OP_SEEK:
                            begin
                                seek_reg[iv]  <= q_item.index;
                                seekv_reg[iv] <= 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_CHECK:
                begin
                    if (!active && !last_voice)
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_SEEK:
                begin
                    if (rem_done)
                    begin
                        pos_reg[k_reg]   <= {FRAME_W'(rem_out), 16'd0};
                        seekv_reg[k_reg] <= 1'b0;
                    end
                end
                S_ACC:
                begin
                    acc_reg  <= acc_reg + {{(ACC_W-17){cl[16]}}, cl[16:0]};
                    accr_reg <= accr_reg + {{(ACC_W-17){cr[16]}}, cr[16:0]};
                    if (wrap_fast)
                    begin
                        pos_reg[k_reg] <= PW'(sum);
                        if (!last_voice)
                        begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                S_ADV:
                begin
                    if (rem_done)
                    begin
                        pos_reg[k_reg] <= {FRAME_W'(rem_out), sum[15:0]};
                        if (!last_voice)
                        begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && (!out_valid_reg || out_pop))
        begin
            out_l_reg <= clip_l;
            out_r_reg <= clip_rr;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_left  = out_l_reg;
    assign out_right = out_r_reg | clip_r;

    // remainder unit is never restarted mid-run
    assert property (@(posedge clk) disable iff (!rst_n) rem_start |-> !rem_busy)
        else $error("remainder unit restarted while busy");

    // waiting states only exist while the remainder unit is running or finishing
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SEEK) || (state_reg == S_ADV)) |-> (rem_busy || rem_done))
        else $error("waiting on idle remainder unit");

    // voice counter stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(k_reg) < 32'(NUM_VOICES))
        else $error("voice counter out of range");

    // an unread output frame is not dropped while a finished frame waits
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && out_valid_reg && !out_pop) |=> out_valid_reg)
        else $error("output frame dropped");

endmodule

`default_nettype wire

[sv/sample_voice_mixer.sv]
// Top level of the sample voice mixer: clip register, front decoder,
// command queue and mixing engine. Depends on svm_pkg and all svm_ modules.
//
//  channel   direction  handshake            payload
//  input     in         push / full          cmd voice frame_index sample_left
//                                            sample_right frame_count enable gain pitch
//  result    out        empty / pop          out_left out_right
//  config    in         cfg_we               cfg_wdata (clip level)
//
// Non-tick commands are executed from the idle state. A tick leaves the queue,
// then walks the voices: a silent voice is only checked, a playing voice is
// checked, read twice, interpolated, scaled and accumulated, plus a remainder
// unit run for a pending seek and another for a position wrap at the loop end;
// the output is loaded once the output register is free.
// The input queue holds 4 items; full rises when it fills while the engine is
// busy ticking or waiting on an unread result.
// Reset clears voice state and the clip level to 0.95; the sample memory is
// not cleared.
`default_nettype none

module sample_voice_mixer
    import svm_pkg::*;
#(
    parameter int NUM_VOICES  = DEF_NUM_VOICES,
    parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  cmd,
    input  wire logic [2:0]  voice,
    input  wire logic [15:0] frame_index,
    input  wire logic [15:0] sample_left,
    input  wire logic [15:0] sample_right,
    input  wire logic [16:0] frame_count,
    input  wire logic        enable,
    input  wire logic [15:0] gain,
    input  wire logic [19:0] pitch,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      out_left,
    output logic [15:0]      out_right,
    input  wire logic        cfg_we,
    input  wire logic [14:0] cfg_wdata
);

    logic [14:0] clip_reg;
    logic        q_full, q_push, q_empty, q_pop;
    item_t       q_in, q_head;
    logic        out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg <= CLIP_RESET;
        end
        else if (cfg_we)
        begin
            clip_reg <= cfg_wdata;
        end
    end

    svm_front #(
        .NUM_VOICES  (NUM_VOICES),
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .voice        (voice),
        .frame_index  (frame_index),
        .sample_left  (sample_left),
        .sample_right (sample_right),
        .frame_count  (frame_count),
        .enable       (enable),
        .gain         (gain),
        .pitch        (pitch),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_in)
    );

    svm_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    svm_engine #(
        .NUM_VOICES (NUM_VOICES),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_item     (q_head),
        .q_pop      (q_pop),
        .clip_level (clip_reg),
        .out_valid  (out_valid),
        .out_pop    (pop),
        .out_left   (out_left),
        .out_right  (out_right)
    );

    assign empty = !out_valid;

endmodule

`default_nettype wire

[sim/sample_voice_mixer_test.sv]
// Self-checking testbench for sample_voice_mixer: directed and random command
// streams against a behavioral mixer, with bursty input and stalled output.
// Depends on svm_pkg and the sample_voice_mixer RTL.
`default_nettype none

class mix_scoreboard;
    // behavioral state of the mixer
    logic [31:0] frames [int];
    logic [31:0] pos [6];
    logic [16:0] len [6];
    bit          on [6];
    logic [15:0] vgain [6];
    logic [19:0] vstep [6];
    logic [15:0] seek_to [6];
    bit          seek_on [6];
    logic [14:0] clip;
    logic [31:0] expected_frames [$];
    int          mismatches;

    function void clear();
        for (int k = 0; k < 6; k++)
        begin
            pos[k] = 0;
            len[k] = 0;
            on[k] = 0;
            vgain[k] = 0;
            vstep[k] = svm_pkg::UNITY_STEP;
            seek_on[k] = 0;
            seek_to[k] = 0;
        end
        clip = svm_pkg::CLIP_RESET;
        mismatches = 0;
    endfunction

    function longint interp(longint a, longint b, longint f);
        return a + ((b - a) * f) / 65536;
    endfunction

    function void note_item(svm_pkg::op_t op, int v, int idx, logic [15:0] sl,
                            logic [15:0] sr, int cnt, bit en, int g, int p);
        longint acl, acr, c, l, r, span, ps, i0, i1, st;
        logic [31:0] w0, w1;
        acl = 0;
        acr = 0;
        if (op != svm_pkg::OP_TICK)
        begin
            if (v >= 6)
                return;
            case (op)
                svm_pkg::OP_WRITE: frames[v * 65536 + idx] = {sl, sr};
                svm_pkg::OP_LOAD:
                begin
                    len[v] = (cnt[16:0] > 17'd65536) ? 17'd65536 : cnt[16:0];
                    on[v] = en;
                    pos[v] = 0;
                    seek_on[v] = 0;
                    vgain[v] = 0;
                    vstep[v] = svm_pkg::UNITY_STEP;
                end
                svm_pkg::OP_GAIN:
                begin
                    vgain[v] = (g[15:0] > 16'd32768) ? 16'd32768 : g[15:0];
                    vstep[v] = p[19:0];
                end
                svm_pkg::OP_SEEK:
                begin
                    seek_to[v] = idx[15:0];
                    seek_on[v] = 1;
                end
                default: ;
            endcase
            return;
        end
        for (int k = 0; k < 6; k++)
        begin
            if (!on[k] || len[k] == 0 || vgain[k] < svm_pkg::MIN_GAIN)
                continue;
            span = longint'(len[k]) << 16;
            if (seek_on[k])
            begin
                pos[k] = 32'((longint'(seek_to[k]) % longint'(len[k])) << 16);
                seek_on[k] = 0;
            end
            st = (vstep[k] < svm_pkg::MIN_STEP) ? svm_pkg::MIN_STEP : vstep[k];
            ps = longint'(pos[k]) % span;
            i0 = ps >> 16;
            i1 = (i0 + 1 < len[k]) ? i0 + 1 : 0;
            w0 = frames[k * 65536 + int'(i0)];
            w1 = frames[k * 65536 + int'(i1)];
            l = interp(longint'($signed(w0[31:16])), longint'($signed(w1[31:16])),
                       ps & 16'hFFFF);
            r = interp(longint'($signed(w0[15:0])), longint'($signed(w1[15:0])),
                       ps & 16'hFFFF);
            acl += (l * longint'(vgain[k])) / 32768;
            acr += (r * longint'(vgain[k])) / 32768;
            pos[k] = 32'((ps + st) % span);
        end
        c = clip;
        if (acl > c) acl = c; else if (acl < -c) acl = -c;
        if (acr > c) acr = c; else if (acr < -c) acr = -c;
        expected_frames.push_back({acl[15:0], acr[15:0]});
    endfunction

    function void check_frame(logic [15:0] ol, logic [15:0] orr);
        logic [31:0] e;
        if (expected_frames.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected frame %h %h", ol, orr);
            return;
        end
        e = expected_frames.pop_front();
        if (e !== {ol, orr})
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("frame mismatch: exp L %h R %h, got L %h R %h",
                         e[31:16], e[15:0], ol, orr);
        end
    endfunction
endclass

module sample_voice_mixer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import svm_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        push = 0;
    logic        full;
    logic [2:0]  cmd = 0;
    logic [2:0]  voice = 0;
    logic [15:0] frame_index = 0;
    logic [15:0] sample_left = 0;
    logic [15:0] sample_right = 0;
    logic [16:0] frame_count = 0;
    logic        enable = 0;
    logic [15:0] gain = 0;
    logic [19:0] pitch = 0;
    logic        empty;
    logic        pop = 0;
    logic [15:0] out_left;
    logic [15:0] out_right;
    logic        cfg_we = 0;
    logic [14:0] cfg_wdata = 0;

    mix_scoreboard mixer_model;
    int  hold_cycles = 0;   // long receiver hold-off, counted by the pop process
    int  written_len [6];   // frames written per voice, so loops read only written data

    sample_voice_mixer DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd), .voice(voice),
        .frame_index(frame_index), .sample_left(sample_left),
        .sample_right(sample_right), .frame_count(frame_count), .enable(enable),
        .gain(gain), .pitch(pitch), .empty(empty), .pop(pop), .out_left(out_left),
        .out_right(out_right), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    initial
    begin
        #5ms;
        $display("sample_voice_mixer_test failed");
        $finish;
    end

    // receiver: pops on its own pattern, checks accepted frames
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            mixer_model.check_frame(out_left, out_right);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pop <= 0;
        end
        else
            pop <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0 && pop);
    end

    task automatic send(op_t op, int v, int idx, int sl, int sr, int cnt, bit en,
                        int g, int p);
        push <= 1;
        cmd <= op;
        voice <= 3'(v);
        frame_index <= 16'(idx);
        sample_left <= 16'(sl);
        sample_right <= 16'(sr);
        frame_count <= 17'(cnt);
        enable <= en;
        gain <= 16'(g);
        pitch <= 20'(p);
        do @(posedge clk); while (full);
        mixer_model.note_item(op, v, idx, 16'(sl), 16'(sr), cnt, en, g, p);
    endtask

    task automatic idle_gap();
        push <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    task automatic drain();
        push <= 0;
        while (mixer_model.expected_frames.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic set_clip(int c);
        drain();
        cfg_we <= 1;
        cfg_wdata <= 15'(c);
        @(posedge clk);
        cfg_we <= 0;
        mixer_model.clip = 15'(c);
    endtask

    // well-formed voice setup: write n frames, load, set gain and pitch
    task automatic load_voice(int v, int n, int g, int p);
        for (int i = 0; i < n; i++)
            send(OP_WRITE, v, i, $urandom, $urandom, 0, 0, 0, 0);
        written_len[v] = n;
        send(OP_LOAD, v, 0, 0, 0, n, 1, 0, 0);
        send(OP_GAIN, v, 0, 0, 0, 0, 0, g, p);
    endtask

    task automatic random_item();
        int r, v;
        r = $urandom_range(0, 99);
        v = $urandom_range(0, 5);
        if (r < 45)
            send(OP_TICK, $urandom_range(0, 7), $urandom, 0, 0, 0, 0, 0, 0);
        else if (r < 60)
            send(OP_WRITE, v, $urandom_range(0, 40), $urandom, $urandom, 0, 0, 0, 0);
        else if (r < 72)
            send(OP_GAIN, v, 0, 0, 0, 0, 0,
                 ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32768),
                 ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 200000));
        else if (r < 84)
            send(OP_SEEK, v, $urandom, 0, 0, 0, 0, 0, 0);
        else if (r < 90)
            // reload within the written span only
            send(OP_LOAD, v, 0, 0, 0, $urandom_range(1, written_len[v]),
                 $urandom_range(0, 1), 0, 0);
        else if (r < 95)
            send(op_t'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom);
        else
            send(OP_WRITE, $urandom_range(6, 7), $urandom, $urandom, $urandom,
                 0, 0, 0, 0);
    endtask

    initial
    begin
        mixer_model = new();
        mixer_model.clear();
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every command, special cases
        send(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        send(OP_WRITE, 0, 0, 16'h7FFF, 16'h8000, 0, 0, 0, 0);
        send(OP_WRITE, 0, 1, 16'h8000, 16'h7FFF, 0, 0, 0, 0);
        written_len[0] = 2;
        send(OP_LOAD, 0, 0, 0, 0, 2, 1, 0, 0);
        send(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0);            // gain zero: silent
        send(OP_GAIN, 0, 0, 0, 0, 0, 0, 3, 65536);
        send(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0);            // gain below floor
        send(OP_GAIN, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0);    // saturated gain, min step
        send(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        send(OP_SEEK, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0);    // seek past loop
        send(OP_SEEK, 0, 1, 0, 0, 0, 0, 0, 0);           // newer seek wins
        send(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        send(OP_GAIN, 0, 0, 0, 0, 0, 0, 32768, 20'hFFFFF);
        send(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        send(OP_LOAD, 1, 0, 0, 0, 0, 1, 0, 0);           // zero length stays silent
        send(OP_GAIN, 1, 0, 0, 0, 0, 0, 32768, 65536);
        send(OP_LOAD, 7, 0, 0, 0, 5, 1, 0, 0);           // bad voice
        send(op_t'(3'd7), 0, 0, 0, 0, 0, 0, 0, 0);       // bad command
        send(OP_TICK, 7, 0, 0, 0, 0, 0, 0, 0);
        send(OP_WRITE, 0, 16'hFFFF, 16'h1234, 16'h4321, 0, 0, 0, 0);
        send(OP_LOAD, 0, 0, 0, 0, 17'h1FFFF, 0, 0, 0);   // length saturates, disabled
        send(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0);

        for (int v = 0; v < 6; v++)
            load_voice(v, $urandom_range(2, 40), $urandom_range(4, 32768),
                       $urandom_range(0, 300000));

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1: set_clip(0);
                2: set_clip(32767);
                3: set_clip($urandom_range(1, 32766));
                4: set_clip(CLIP_RESET);
                default: ;
            endcase
            for (int n = 0; n < 400; )
            begin
                int burst;
                burst = $urandom_range(1, 30);
                for (int b = 0; b < burst; b++, n++)
                    random_item();
                if (n > 150 && n < 190 && ph == 1)
                    hold_cycles = 300;
                if ($urandom_range(0, 2) != 0)
                    idle_gap();
                else if ($urandom_range(0, 20) == 0)
                    drain();
            end
        end

        drain();
        if (mixer_model.mismatches == 0)
            $display("sample_voice_mixer_test passed");
        else
            $display("sample_voice_mixer_test failed");
        $finish;
    end
endmodule

`default_nettype wire
